@@ hw/rtl/xcfd_pkg.sv @@
// shared types and codes for the xor checked frame deframer
package xcfd_pkg;

  localparam int ByteW = 8;
  localparam int KindW = 3;

  localparam logic [ByteW-1:0] HeaderReset = 8'd60;

  // field kind codes
  localparam logic [KindW-1:0] KIND_OP      = 3'd0;
  localparam logic [KindW-1:0] KIND_TARGET  = 3'd1;
  localparam logic [KindW-1:0] KIND_LENGTH  = 3'd2;
  localparam logic [KindW-1:0] KIND_PAYLOAD = 3'd3;
  localparam logic [KindW-1:0] KIND_END     = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [KindW-1:0] field_kind;
    logic             frame_good;
  } result_t;

endpackage

@@ hw/rtl/xcfd_in_stage.sv @@
// input register holding one received byte
module xcfd_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [xcfd_pkg::ByteW-1:0] in_byte,
  input  logic                      pop,
  output logic                      held_valid,
  output logic [xcfd_pkg::ByteW-1:0] held_byte
);
  import xcfd_pkg::*;

  // room when empty or when the held byte leaves this cycle
  assign in_ready = !held_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

@@ hw/rtl/xcfd_parser.sv @@
// frame state machine: header hunt, field tagging and xor check
module xcfd_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       header_wr,
  input  logic [xcfd_pkg::ByteW-1:0] header_byte,
  input  logic                       step,
  input  logic [xcfd_pkg::ByteW-1:0] rx_byte,
  output logic                       res_valid,
  output xcfd_pkg::result_t          res
);
  import xcfd_pkg::*;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_OP      = 3'd1;
  localparam logic [2:0] PH_TARGET  = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CHECK   = 3'd5;

  logic [ByteW-1:0] header;
  logic [2:0]       phase;
  logic [2:0]       phase_next;
  logic [ByteW-1:0] bytes_left;
  logic [ByteW-1:0] bytes_left_next;
  logic [ByteW-1:0] running_xor;
  logic [ByteW-1:0] running_xor_next;
  logic [ByteW-1:0] left_dec;

  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    running_xor_next = running_xor ^ rx_byte;
    res_valid        = 1'b1;
    res.out_byte     = rx_byte;
    res.field_kind   = KIND_OP;
    res.frame_good   = 1'b0;
    unique case (phase)
      PH_OP: begin
        phase_next = PH_TARGET;
      end
      PH_TARGET: begin
        phase_next     = PH_LENGTH;
        res.field_kind = KIND_TARGET;
      end
      PH_LENGTH: begin
        bytes_left_next = rx_byte;
        phase_next      = (rx_byte != 8'd0) ? PH_PAYLOAD : PH_CHECK;
        res.field_kind  = KIND_LENGTH;
      end
      PH_PAYLOAD: begin
        bytes_left_next = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = PH_CHECK;
        end
        res.field_kind = KIND_PAYLOAD;
      end
      PH_CHECK: begin
        phase_next       = PH_HUNT;
        bytes_left_next  = 8'd0;
        running_xor_next = 8'd0;
        res.field_kind   = KIND_END;
        res.frame_good   = (running_xor == rx_byte);
      end
      default: begin
        // hunting, and any unused code
        res_valid        = 1'b0;
        phase_next       = PH_HUNT;
        running_xor_next = running_xor;
        if (rx_byte == header) begin
          running_xor_next = rx_byte;
          phase_next       = PH_OP;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      bytes_left  <= 8'd0;
      running_xor <= 8'd0;
    end else if (step) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      running_xor <= running_xor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header <= HeaderReset;
    end else if (header_wr) begin
      header <= header_byte;
    end
  end

endmodule

@@ hw/rtl/xcfd_out_stage.sv @@
// result register toward the master side
module xcfd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              load_valid,
  input  xcfd_pkg::result_t load_res,
  output logic              out_valid,
  input  logic              out_ready,
  output xcfd_pkg::result_t out_res,
  output logic              free
);
  import xcfd_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule

@@ hw/rtl/xor_checked_frame_deframer.sv @@
// top level of the xor checked frame deframer
//
// received serial bytes enter on the s_axis channel, one per transaction.
// the block hunts for the header byte, then tags each frame byte that
// follows (operation, target, length, payload) and sends it out on the
// m_axis channel; the checksum byte leaves as a frame-end transaction
// whose good flag says whether the xor of the frame bytes matched.
// the header byte itself and bytes seen while hunting produce nothing.
// header_byte is set through header_wr / header_byte; the user must do so only
// while the block idles, and the block itself does not enforce it.
// path: a byte accepted on s_axis is registered in the input register, run
// through the frame state machine and lands in the result register, from
// which its result shows on m_axis; a stall on m_axis holds it in between.
// throughput: one byte per cycle while m_axis does not stall, set by the state
// update between the input register and the result register.
// reset empties both registers, clears the frame state and loads header 60.
// when the receiver stalls, the result register holds; the input register
// still takes a byte if it is empty, then s_axis_tready drops until m_axis moves.
module xor_checked_frame_deframer (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       header_wr,
  input  logic [xcfd_pkg::ByteW-1:0] header_byte,
  // received bytes
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // rx_byte[7:0]
  // tagged frame bytes
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // out_byte[7:0]
  output logic [3:0]                 m_axis_tuser   // field_kind[2:0], frame_good[3]
);
  import xcfd_pkg::*;

  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             out_free;
  logic             adv;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  // the held byte moves on whenever the result register can take it
  assign adv = held_valid && out_free;

  xcfd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .pop        (adv),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  xcfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .header_wr   (header_wr),
    .header_byte (header_byte),
    .step        (adv),
    .rx_byte     (held_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  xcfd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (adv),
    .load_valid (res_valid),
    .load_res   (res),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res),
    .free       (out_free)
  );

  // result packing: byte in tdata, kind and good flag in tuser
  assign m_axis_tdata = out_res.out_byte;
  assign m_axis_tuser = {out_res.frame_good, out_res.field_kind};

endmodule
